### rtl/core/olist_pkg.sv
package olist_pkg;

    // field widths of one command and one result
    localparam int FUNC_W      = 3;
    localparam int POS_W       = 6;
    localparam int VAL_W       = 32;
    localparam int CNT_W       = 7;
    localparam int IN_TDATA_W  = 48;
    localparam int OUT_TDATA_W = 56;

    // command codes
    typedef enum logic [FUNC_W-1:0] {
        FN_INSERT_AT     = 3'd0,
        FN_INSERT_SORTED = 3'd1,
        FN_ERASE_AT      = 3'd2,
        FN_REMOVE_VALUE  = 3'd3,
        FN_FIND          = 3'd4,
        FN_GET           = 3'd5,
        FN_SET           = 3'd6
    } t_func;

    // sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_REMOVE
    } t_state;

    // per-cell control from the sequencer
    typedef struct packed {
        logic live;
        logic load_flag;
        logic cmp_ge;
        logic take_val;
        logic take_left;
        logic take_right;
    } t_cell_ctl;

    // result beat, status in the lowest bit
    typedef struct packed {
        logic             is_empty;
        logic [CNT_W-1:0] item_count;
        logic [CNT_W-1:0] removed_count;
        logic [VAL_W-1:0] value_out;
        logic [POS_W-1:0] position_out;
        logic             status;
    } t_result;

endpackage

### rtl/core/olist_cell.sv
module olist_cell (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  olist_pkg::t_cell_ctl    i_ctl,
    input  logic [olist_pkg::VAL_W-1:0] i_value,
    input  logic [olist_pkg::VAL_W-1:0] i_left_entry,
    input  logic [olist_pkg::VAL_W-1:0] i_right_entry,
    input  logic                    i_right_flag,
    output logic [olist_pkg::VAL_W-1:0] o_entry,
    output logic                    o_flag
);
    import olist_pkg::*;

    logic [VAL_W-1:0] r_entry;
    logic [VAL_W-1:0] n_entry;
    logic             r_flag;
    logic             n_flag;
    logic             w_hit;

    // compare against the command value: greater-or-equal for sorted insert, else equal
    assign w_hit = i_ctl.cmp_ge ? (r_entry >= i_value) : (r_entry == i_value);

    // entry select: new value, shift up from the left, shift down from the right
    always_comb begin
        if (i_ctl.take_val) begin
            n_entry = i_value;
        end else if (i_ctl.take_left) begin
            n_entry = i_left_entry;
        end else if (i_ctl.take_right) begin
            n_entry = i_right_entry;
        end else begin
            n_entry = r_entry;
        end
    end

    // match flag travels with its entry while compacting
    always_comb begin
        if (i_ctl.load_flag) begin
            n_flag = i_ctl.live & w_hit;
        end else if (i_ctl.take_right) begin
            n_flag = i_right_flag;
        end else begin
            n_flag = r_flag;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flag <= 1'b0;
        end else begin
            r_flag <= n_flag;
        end
    end

    assign o_entry = r_entry;
    assign o_flag  = r_flag;

endmodule

### rtl/core/olist_scan.sv
module olist_scan #(
    parameter int N = 64
) (
    input  logic [N-1:0]         i_flags,
    output logic [N-1:0]         o_incl,
    output logic [N-1:0]         o_first,
    output logic                 o_any,
    output logic [$clog2(N)-1:0] o_first_idx
);
    import olist_pkg::*;

    localparam int IW = $clog2(N);

    // prefix or in log steps: o_incl[i] is set when any flag at or below i is set
    always_comb begin
        logic [N-1:0] v_acc;
        v_acc = i_flags;
        for (int s = 1; s < N; s = s * 2) begin
            v_acc = v_acc | (v_acc << s);
        end
        o_incl = v_acc;
    end

    // one-hot of the lowest set flag
    assign o_first = o_incl & ~{o_incl[N-2:0], 1'b0};
    assign o_any   = o_incl[N-1];

    // encode the one-hot into an index
    always_comb begin
        logic [IW-1:0] v_idx;
        v_idx = '0;
        for (int i = 0; i < N; i++) begin
            if (o_first[i]) begin
                v_idx = v_idx | IW'(i);
            end
        end
        o_first_idx = v_idx;
    end

endmodule

### rtl/core/ordered_list_engine_unit.sv
// Bounded list of up to DEPTH 32-bit values held in a row of cells, one entry per cell,
// with a live count and a capacity register (limit in force is min(capacity, DEPTH)).
// A command beat is taken in ST_IDLE, where every cell compares its entry with the
// command value, and carried out in ST_EXEC once the result register is free, where
// all cells shift, load or hold at once; insert_at, insert_sorted, erase_at, find,
// get and set finish there. remove_value goes on to ST_REMOVE, which compacts the
// chain by one matching entry per cycle. Results sit in an output register, so the
// next command is taken while a result still waits to be read. Capacity may be
// written at any cycle while no command is in flight; o_cfg_ready is always high.
module ordered_list_engine_unit #(
    parameter int DEPTH = 64
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // command beat: func [2:0], position [8:3], value [40:9], zero [47:41]
    input  logic                                i_s_tvalid,
    output logic                                o_s_tready,
    input  logic [olist_pkg::IN_TDATA_W-1:0]    i_s_tdata,
    // result beat: status [0], position_out [6:1], value_out [38:7],
    // removed_count [45:39], item_count [52:46], is_empty [53], zero [55:54]
    output logic                                o_m_tvalid,
    input  logic                                i_m_tready,
    output logic [olist_pkg::OUT_TDATA_W-1:0]   o_m_tdata,
    // capacity write
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [olist_pkg::CNT_W-1:0]         i_cfg_data
);
    import olist_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);
    localparam int IW = $clog2(DEPTH);
    localparam int XW = (CW > CNT_W) ? CW : CNT_W;

    t_state           r_state;
    t_state           n_state;
    t_func            r_func;
    logic [POS_W-1:0] r_pos;
    logic [VAL_W-1:0] r_val;
    logic [CW-1:0]    r_count;
    logic [CW-1:0]    n_count;
    logic [CW-1:0]    r_removed;
    logic [CNT_W-1:0] r_cap;
    logic             r_out_valid;
    t_result          r_out;
    t_result          w_result;

    logic             w_accept;
    logic             w_out_free;
    logic             w_exec_fire;
    logic             w_rem_step;
    logic             w_rem_done;
    logic             w_result_load;
    t_func            w_in_func;
    logic [VAL_W-1:0] w_cell_value;

    logic [XW-1:0]    w_cnt_x;
    logic [XW-1:0]    w_pos_x;
    logic [XW-1:0]    w_sort_idx;
    logic             w_room;
    logic             w_ok_ins_at;
    logic             w_ok_pos;

    logic [VAL_W-1:0] w_entry [DEPTH];
    logic [VAL_W-1:0] w_sel   [DEPTH];
    logic [VAL_W-1:0] w_get_val;
    logic [DEPTH-1:0] w_flag;
    logic [DEPTH-1:0] w_incl;
    logic [DEPTH-1:0] w_incl_prev;
    logic [DEPTH-1:0] w_first;
    logic             w_any;
    logic [IW-1:0]    w_first_idx;
    t_cell_ctl        w_ctl [DEPTH];

    // handshakes
    assign w_accept    = i_s_tvalid && o_s_tready;
    assign w_out_free  = !r_out_valid || i_m_tready;
    assign w_in_func   = t_func'(i_s_tdata[FUNC_W-1:0]);
    assign o_cfg_ready = 1'b1;

    // capacity register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap <= CNT_W'(64);
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_cap <= i_cfg_data;
        end
    end

    // command register
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_func <= w_in_func;
            r_pos  <= i_s_tdata[FUNC_W +: POS_W];
            r_val  <= i_s_tdata[FUNC_W+POS_W +: VAL_W];
        end
    end

    // range checks on the held command
    assign w_cnt_x     = XW'(r_count);
    assign w_pos_x     = XW'(r_pos);
    assign w_room      = (w_cnt_x < XW'(r_cap)) && (r_count < CW'(DEPTH));
    assign w_ok_ins_at = w_room && (w_pos_x <= w_cnt_x);
    assign w_ok_pos    = w_pos_x < w_cnt_x;
    assign w_sort_idx  = w_any ? XW'(w_first_idx) : w_cnt_x;

    // cells compare against the incoming value at accept, the held one afterwards
    assign w_cell_value = (r_state == ST_IDLE) ? i_s_tdata[FUNC_W+POS_W +: VAL_W] : r_val;

    // first flagged cell and prefix
    olist_scan #(
        .N (DEPTH)
    ) u_scan (
        .i_flags     (w_flag),
        .o_incl      (w_incl),
        .o_first     (w_first),
        .o_any       (w_any),
        .o_first_idx (w_first_idx)
    );

    assign w_incl_prev = {w_incl[DEPTH-2:0], 1'b0};

    // chain of cells
    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        logic [XW-1:0]    w_idx;
        logic [VAL_W-1:0] w_left;
        logic [VAL_W-1:0] w_right;
        logic             w_right_flag;

        assign w_idx = XW'(i);

        if (i == 0) begin : g_head
            assign w_left = '0;
        end else begin : g_body
            assign w_left = w_entry[i-1];
        end

        if (i == DEPTH - 1) begin : g_tail
            assign w_right      = '0;
            assign w_right_flag = 1'b0;
        end else begin : g_inner
            assign w_right      = w_entry[i+1];
            assign w_right_flag = w_flag[i+1];
        end

        // control for this cell
        always_comb begin
            w_ctl[i].live       = w_idx < XW'(r_count);
            w_ctl[i].load_flag  = w_accept;
            w_ctl[i].cmp_ge     = (r_state == ST_IDLE) && (w_in_func == FN_INSERT_SORTED);
            w_ctl[i].take_val   = w_exec_fire && (
                ((r_func == FN_INSERT_AT) && w_ok_ins_at && (w_idx == w_pos_x)) ||
                ((r_func == FN_INSERT_SORTED) && w_room &&
                 (w_first[i] || (!w_any && (w_idx == w_cnt_x)))) ||
                ((r_func == FN_SET) && w_ok_pos && (w_idx == w_pos_x)));
            w_ctl[i].take_left  = w_exec_fire && (
                ((r_func == FN_INSERT_AT) && w_ok_ins_at && (w_idx > w_pos_x)) ||
                ((r_func == FN_INSERT_SORTED) && w_room && w_incl_prev[i]));
            w_ctl[i].take_right =
                (w_exec_fire && (r_func == FN_ERASE_AT) && w_ok_pos && (w_idx >= w_pos_x)) ||
                (w_rem_step && w_incl[i]);
        end

        // read port for get
        assign w_sel[i] = (w_idx == w_pos_x) ? w_entry[i] : '0;

        olist_cell u_cell (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_ctl         (w_ctl[i]),
            .i_value       (w_cell_value),
            .i_left_entry  (w_left),
            .i_right_entry (w_right),
            .i_right_flag  (w_right_flag),
            .o_entry       (w_entry[i]),
            .o_flag        (w_flag[i])
        );
    end

    // or-reduce the selected entry
    always_comb begin
        logic [VAL_W-1:0] v_acc;
        v_acc = '0;
        for (int i = 0; i < DEPTH; i++) begin
            v_acc = v_acc | w_sel[i];
        end
        w_get_val = v_acc;
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (r_func == FN_REMOVE_VALUE) begin
                    n_state = ST_REMOVE;
                end else if (w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            ST_REMOVE: begin
                if (!w_any && w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // sequencer outputs
    always_comb begin
        o_s_tready  = 1'b0;
        w_exec_fire = 1'b0;
        w_rem_step  = 1'b0;
        w_rem_done  = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_s_tready = 1'b1;
            end
            ST_EXEC: begin
                w_exec_fire = (r_func != FN_REMOVE_VALUE) && w_out_free;
            end
            ST_REMOVE: begin
                w_rem_step = w_any;
                w_rem_done = !w_any && w_out_free;
            end
            default: begin
                o_s_tready = 1'b0;
            end
        endcase
    end

    assign w_result_load = w_exec_fire || w_rem_done;

    // count after this cycle
    always_comb begin
        n_count = r_count;
        if (w_exec_fire) begin
            case (r_func)
                FN_INSERT_AT: begin
                    if (w_ok_ins_at) begin
                        n_count = r_count + CW'(1);
                    end
                end
                FN_INSERT_SORTED: begin
                    if (w_room) begin
                        n_count = r_count + CW'(1);
                    end
                end
                FN_ERASE_AT: begin
                    if (w_ok_pos) begin
                        n_count = r_count - CW'(1);
                    end
                end
                default: begin
                    n_count = r_count;
                end
            endcase
        end else if (w_rem_step) begin
            n_count = r_count - CW'(1);
        end
    end

    // result fields
    always_comb begin
        w_result        = '0;
        w_result.status = 1'b1;
        if (r_state == ST_REMOVE) begin
            w_result.status        = (r_removed == '0);
            w_result.removed_count = CNT_W'(r_removed);
        end else begin
            case (r_func)
                FN_INSERT_AT: begin
                    if (w_ok_ins_at) begin
                        w_result.status       = 1'b0;
                        w_result.position_out = r_pos;
                    end
                end
                FN_INSERT_SORTED: begin
                    if (w_room) begin
                        w_result.status       = 1'b0;
                        w_result.position_out = POS_W'(w_sort_idx);
                    end
                end
                FN_ERASE_AT, FN_SET: begin
                    w_result.status = !w_ok_pos;
                end
                FN_FIND: begin
                    if (w_any) begin
                        w_result.status       = 1'b0;
                        w_result.position_out = POS_W'(w_first_idx);
                    end
                end
                FN_GET: begin
                    if (w_ok_pos) begin
                        w_result.status    = 1'b0;
                        w_result.value_out = w_get_val;
                    end
                end
                default: begin
                    w_result.status = 1'b1;
                end
            endcase
        end
        w_result.item_count = CNT_W'(n_count);
        w_result.is_empty   = (n_count == '0);
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_removed   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            if (w_accept) begin
                r_removed <= '0;
            end else if (w_rem_step) begin
                r_removed <= r_removed + CW'(1);
            end
            if (w_result_load) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (w_result_load) begin
            r_out <= w_result;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = OUT_TDATA_W'(r_out);

endmodule

### rtl/core/olist_checker.sv
module olist_assertions (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               i_s_tvalid,
    input logic                               o_s_tready,
    input logic                               o_m_tvalid,
    input logic                               i_m_tready,
    input logic [olist_pkg::OUT_TDATA_W-1:0]  o_m_tdata
);
    import olist_pkg::*;

    // no result beat straight out of reset
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result beat valid after reset");

    // one command beat at a time: ready drops after a beat is taken
    a_one_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready |=> !o_s_tready)
        else $error("command beat taken while another is in flight");

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("result beat changed while stalled");

    // emptiness agrees with the count
    a_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tdata[53] == (o_m_tdata[52:46] == 7'd0)))
        else $error("is_empty disagrees with item_count");

    // removed entries or a read value only come with a good status
    a_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && ((o_m_tdata[45:39] != 7'd0) || (o_m_tdata[38:7] != 32'd0))
        |-> !o_m_tdata[0])
        else $error("payload present with failing status");

endmodule

bind ordered_list_engine_unit olist_assertions u_olist_assertions (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata)
);
